// ===== hdl/lob_pkg.sv =====
// shared types, sizes and helper functions for the order book engine
// no dependencies; imported by every module of the block
package lob_pkg;

   localparam int ORD_SLOTS = 1024;
   localparam int LVL_SIDE  = 64;
   localparam int LVL_TOTAL = 2 * LVL_SIDE;
   localparam int ORD_AW    = $clog2(ORD_SLOTS);
   localparam int LVL_AW    = $clog2(LVL_TOTAL);
   localparam int CNT_W     = ($clog2(ORD_SLOTS + 1) > 11) ? $clog2(ORD_SLOTS + 1) : 11;
   localparam int OUT_CNT_W = 11;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_MODIFY = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUP       = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] ident;
      logic        side;
      logic [31:0] price;
      logic [31:0] size;
   } ord_entry_type;

   typedef struct packed {
      logic [31:0]      price;
      logic [31:0]      volume;
      logic [CNT_W-1:0] count;
   } lvl_entry_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic capture;
      logic ord_start;
      logic ord_clear;
      logic ord_read;
      logic lvl_start;
      logic lvl_search;
      logic best_start;
      logic lvl_best;
      logic update;
      logic load_rsp;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic ord_last;
      logic lvl_side_last;
      logic lvl_all_last;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

   function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
      return (b > a) ? 32'd0 : a - b;
   endfunction

endpackage

// ===== hdl/limit_order_book_engine.sv =====
// order book engine: the order id scan reads the order memory one slot a cycle,
// then the side's levels and then all levels for the best prices, one per cycle
// a new word is taken only when the last one is through; a waiting response does not block input
// after reset a clearing pass over all ORD_SLOTS slots (1024) empties the order table,
// with req_stall high; level valid bits clear at once
module limit_order_book_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [31:0] req_qty,
   input  logic [31:0] req_price_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_level_volume,
   output logic [10:0] rsp_level_orders,
   output logic        rsp_best_bid_valid,
   output logic [31:0] rsp_best_bid_price,
   output logic [31:0] rsp_best_bid_volume,
   output logic        rsp_best_ask_valid,
   output logic [31:0] rsp_best_ask_price,
   output logic [31:0] rsp_best_ask_volume
);
   import lob_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   lob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables and datapath
   lob_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req_mode),
      .req_order_id        (req_order_id),
      .req_side            (req_side),
      .req_qty             (req_qty),
      .req_price_ticks     (req_price_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_level_volume    (rsp_level_volume),
      .rsp_level_orders    (rsp_level_orders),
      .rsp_best_bid_valid  (rsp_best_bid_valid),
      .rsp_best_bid_price  (rsp_best_bid_price),
      .rsp_best_bid_volume (rsp_best_bid_volume),
      .rsp_best_ask_valid  (rsp_best_ask_valid),
      .rsp_best_ask_price  (rsp_best_ask_price),
      .rsp_best_ask_volume (rsp_best_ask_volume)
   );

endmodule

// ===== hdl/lob_ctrl.sv =====
// sequencer for the order book engine: clear pass, scans, update, response
// depends on lob_pkg
module lob_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lob_pkg::sts_type sts,
   output lob_pkg::cmd_type cmd
);
   import lob_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b00_0000_0001,
      S_IDLE   = 10'b00_0000_0010,
      S_OSCAN  = 10'b00_0000_0100,
      S_OWAIT  = 10'b00_0000_1000,
      S_LSCAN  = 10'b00_0001_0000,
      S_LWAIT  = 10'b00_0010_0000,
      S_UPDATE = 10'b00_0100_0000,
      S_BSCAN  = 10'b00_1000_0000,
      S_BWAIT  = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.ord_clear = 1'b1;
            if (sts.ord_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.ord_start = 1'b1;
               cmd.lvl_start = 1'b1;
               state_in      = S_OSCAN;
            end
         end
         S_OSCAN: begin
            cmd.ord_read = 1'b1;
            if (sts.ord_last) state_in = S_OWAIT;
         end
         S_OWAIT: begin
            state_in = S_LSCAN;
         end
         S_LSCAN: begin
            cmd.lvl_search = 1'b1;
            if (sts.lvl_side_last) state_in = S_LWAIT;
         end
         S_LWAIT: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update     = 1'b1;
            cmd.lvl_start  = 1'b1;
            cmd.best_start = 1'b1;
            state_in       = S_BSCAN;
         end
         S_BSCAN: begin
            cmd.lvl_best = 1'b1;
            if (sts.lvl_all_last) state_in = S_BWAIT;
         end
         S_BWAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hdl/lob_dp.sv =====
// datapath: order and level memories, scan compare, update and response words
// depends on lob_pkg
module lob_dp (
   input  logic             clock,
   input  logic             reset,
   input  lob_pkg::cmd_type cmd,
   output lob_pkg::sts_type sts,
   input  logic [1:0]       req_mode,
   input  logic [31:0]      req_order_id,
   input  logic             req_side,
   input  logic [31:0]      req_qty,
   input  logic [31:0]      req_price_ticks,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_level_volume,
   output logic [10:0]      rsp_level_orders,
   output logic             rsp_best_bid_valid,
   output logic [31:0]      rsp_best_bid_price,
   output logic [31:0]      rsp_best_bid_volume,
   output logic             rsp_best_ask_valid,
   output logic [31:0]      rsp_best_ask_price,
   output logic [31:0]      rsp_best_ask_volume
);
   import lob_pkg::*;

   // captured request word
   mode_type    mode_ff;
   logic [31:0] id_ff, qty_ff, price_ff;
   logic        side_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         id_ff    <= req_order_id;
         side_ff  <= req_side;
         qty_ff   <= req_qty;
         price_ff <= req_price_ticks;
      end
   end

   // order memory with registered read
   ord_entry_type     ord_mem [ORD_SLOTS];
   ord_entry_type     ord_rd_ff;
   logic [ORD_AW-1:0] ord_ridx_ff;
   logic              ord_rv_ff;
   logic [ORD_AW-1:0] ocnt_ff, ocnt_in;
   logic              ord_we;
   logic [ORD_AW-1:0] ord_waddr;
   ord_entry_type     ord_wdata;
   logic              upd_ord_we;
   logic [ORD_AW-1:0] upd_ord_waddr;
   ord_entry_type     upd_ord_wdata;

   assign ord_we    = cmd.ord_clear | upd_ord_we;
   assign ord_waddr = cmd.ord_clear ? ocnt_ff : upd_ord_waddr;
   assign ord_wdata = cmd.ord_clear ? ord_entry_type'('0) : upd_ord_wdata;

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
      if (cmd.ord_read) begin
         ord_rd_ff   <= ord_mem[ocnt_ff];
         ord_ridx_ff <= ocnt_ff;
      end
   end

   // order scan counter
   always_comb begin
      ocnt_in = ocnt_ff;
      if (cmd.ord_start) ocnt_in = '0;
      else if (cmd.ord_read || cmd.ord_clear) ocnt_in = ORD_AW'(ocnt_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff   <= '0;
         ord_rv_ff <= 1'b0;
      end else begin
         ocnt_ff   <= ocnt_in;
         ord_rv_ff <= cmd.ord_read;
      end
   end

   // order match and first free slot
   logic              ofound_ff, ofree_ff;
   logic [ORD_AW-1:0] ofound_idx_ff, ofree_idx_ff;
   ord_entry_type     ofent_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         ofound_ff <= 1'b0;
         ofree_ff  <= 1'b0;
      end else if (ord_rv_ff) begin
         if (ord_rd_ff.valid && ord_rd_ff.ident == id_ff && !ofound_ff) begin
            ofound_ff     <= 1'b1;
            ofound_idx_ff <= ord_ridx_ff;
            ofent_ff      <= ord_rd_ff;
         end
         if (!ord_rd_ff.valid && !ofree_ff) begin
            ofree_ff     <= 1'b1;
            ofree_idx_ff <= ord_ridx_ff;
         end
      end
   end

   // level search target: request for add and query, resting order otherwise
   logic        tgt_side;
   logic [31:0] tgt_price;
   assign tgt_side  = (mode_ff == MODE_ADD || mode_ff == MODE_QUERY) ? side_ff : ofent_ff.side;
   assign tgt_price = (mode_ff == MODE_ADD || mode_ff == MODE_QUERY) ? price_ff
                                                                      : ofent_ff.price;

   // level memory, valid bits in flops
   lvl_entry_type     lvl_mem [LVL_TOTAL];
   logic [LVL_TOTAL-1:0] lvl_valid_ff;
   lvl_entry_type     lvl_rd_ff;
   logic              lvl_rdv_ff;
   logic [LVL_AW-1:0] lvl_ridx_ff;
   logic              lvl_rs_ff, lvl_rb_ff;
   logic [LVL_AW-1:0] lcnt_ff, lcnt_in;
   logic [LVL_AW-1:0] lvl_raddr;
   logic              upd_lvl_we, upd_lvl_set, upd_lvl_clr;
   logic [LVL_AW-1:0] upd_lvl_addr;
   lvl_entry_type     upd_lvl_wdata;

   assign lvl_raddr = cmd.lvl_best ? lcnt_ff
                    : (tgt_side ? LVL_AW'(LVL_SIDE) + lcnt_ff : lcnt_ff);

   always_ff @(posedge clock) begin
      if (upd_lvl_we) lvl_mem[upd_lvl_addr] <= upd_lvl_wdata;
      if (cmd.lvl_search || cmd.lvl_best) begin
         lvl_rd_ff   <= lvl_mem[lvl_raddr];
         lvl_rdv_ff  <= lvl_valid_ff[lvl_raddr];
         lvl_ridx_ff <= lvl_raddr;
      end
   end

   always_comb begin
      lcnt_in = lcnt_ff;
      if (cmd.lvl_start) lcnt_in = '0;
      else if (cmd.lvl_search || cmd.lvl_best) lcnt_in = LVL_AW'(lcnt_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcnt_ff      <= '0;
         lvl_rs_ff    <= 1'b0;
         lvl_rb_ff    <= 1'b0;
         lvl_valid_ff <= '0;
      end else begin
         lcnt_ff   <= lcnt_in;
         lvl_rs_ff <= cmd.lvl_search;
         lvl_rb_ff <= cmd.lvl_best;
         if (upd_lvl_set) lvl_valid_ff[upd_lvl_addr] <= 1'b1;
         if (upd_lvl_clr) lvl_valid_ff[upd_lvl_addr] <= 1'b0;
      end
   end

   // level match and first free level on the target side
   logic              lfound_ff, lfree_ff;
   logic [LVL_AW-1:0] lfound_idx_ff, lfree_idx_ff;
   lvl_entry_type     lent_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         lfound_ff <= 1'b0;
         lfree_ff  <= 1'b0;
      end else if (lvl_rs_ff) begin
         if (lvl_rdv_ff && lvl_rd_ff.price == tgt_price && !lfound_ff) begin
            lfound_ff     <= 1'b1;
            lfound_idx_ff <= lvl_ridx_ff;
            lent_ff       <= lvl_rd_ff;
         end
         if (!lvl_rdv_ff && !lfree_ff) begin
            lfree_ff     <= 1'b1;
            lfree_idx_ff <= lvl_ridx_ff;
         end
      end
   end

   // update step: status, result level word and table writes
   status_type       res_status;
   logic [31:0]      res_vol;
   logic [CNT_W-1:0] res_cnt;
   lvl_entry_type    base_lvl;
   logic [31:0]      rem_vol;
   logic [CNT_W-1:0] rem_cnt;

   always_comb begin
      res_status    = ST_OK;
      res_vol       = '0;
      res_cnt       = '0;
      upd_ord_we    = 1'b0;
      upd_ord_waddr = ofound_idx_ff;
      upd_ord_wdata = ofent_ff;
      upd_lvl_we    = 1'b0;
      upd_lvl_set   = 1'b0;
      upd_lvl_clr   = 1'b0;
      upd_lvl_addr  = lfound_idx_ff;
      upd_lvl_wdata = lent_ff;
      base_lvl      = lent_ff;
      rem_vol       = floor_sub(lent_ff.volume, ofent_ff.size);
      rem_cnt       = (lent_ff.count != '0) ? CNT_W'(lent_ff.count - 1'b1) : '0;
      if (cmd.update) begin
         unique case (mode_ff)
            MODE_ADD: begin
               if (ofound_ff) begin
                  res_status = ST_DUP;
               end else if (!ofree_ff || (!lfound_ff && !lfree_ff)) begin
                  res_status = ST_FULL;
               end else begin
                  if (!lfound_ff) begin
                     upd_lvl_addr = lfree_idx_ff;
                     base_lvl     = '{price: price_ff, volume: 32'd0, count: '0};
                  end
                  res_vol       = sat_add(base_lvl.volume, qty_ff);
                  res_cnt       = CNT_W'(base_lvl.count + 1'b1);
                  upd_lvl_we    = 1'b1;
                  upd_lvl_set   = 1'b1;
                  upd_lvl_wdata = '{price: base_lvl.price, volume: res_vol, count: res_cnt};
                  upd_ord_we    = 1'b1;
                  upd_ord_waddr = ofree_idx_ff;
                  upd_ord_wdata = '{valid: 1'b1, ident: id_ff, side: side_ff,
                                    price: price_ff, size: qty_ff};
               end
            end
            MODE_REMOVE, MODE_MODIFY: begin
               if (!ofound_ff || !lfound_ff) begin
                  res_status = ST_NOT_FOUND;
               end else if (mode_ff == MODE_REMOVE) begin
                  upd_ord_we          = 1'b1;
                  upd_ord_wdata.valid = 1'b0;
                  if (rem_cnt == '0) begin
                     upd_lvl_clr = 1'b1;
                  end else begin
                     res_vol       = rem_vol;
                     res_cnt       = rem_cnt;
                     upd_lvl_we    = 1'b1;
                     upd_lvl_wdata = '{price: lent_ff.price, volume: rem_vol, count: rem_cnt};
                  end
               end else begin
                  res_vol            = sat_add(rem_vol, qty_ff);
                  res_cnt            = lent_ff.count;
                  upd_ord_we         = 1'b1;
                  upd_ord_wdata.size = qty_ff;
                  upd_lvl_we         = 1'b1;
                  upd_lvl_wdata.volume = res_vol;
               end
            end
            MODE_QUERY: begin
               if (!lfound_ff) begin
                  res_status = ST_NOT_FOUND;
               end else begin
                  res_vol = lent_ff.volume;
                  res_cnt = lent_ff.count;
               end
            end
            default: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   // result word of the update step
   status_type  res_status_ff;
   logic [31:0] res_vol_ff;
   logic [10:0] res_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_status_ff <= res_status;
         res_vol_ff    <= res_vol;
         res_cnt_ff    <= (res_cnt > CNT_W'(2047)) ? 11'h7ff : res_cnt[OUT_CNT_W-1:0];
      end
   end

   // best bid and ask scan over all levels
   logic        bb_v_ff, ba_v_ff;
   logic [31:0] bb_p_ff, bb_q_ff, ba_p_ff, ba_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.best_start) begin
         bb_v_ff <= 1'b0;
         bb_p_ff <= '0;
         bb_q_ff <= '0;
         ba_v_ff <= 1'b0;
         ba_p_ff <= '0;
         ba_q_ff <= '0;
      end else if (lvl_rb_ff && lvl_rdv_ff) begin
         if (lvl_ridx_ff < LVL_AW'(LVL_SIDE)) begin
            if (!bb_v_ff || lvl_rd_ff.price > bb_p_ff) begin
               bb_v_ff <= 1'b1;
               bb_p_ff <= lvl_rd_ff.price;
               bb_q_ff <= lvl_rd_ff.volume;
            end
         end else begin
            if (!ba_v_ff || lvl_rd_ff.price < ba_p_ff) begin
               ba_v_ff <= 1'b1;
               ba_p_ff <= lvl_rd_ff.price;
               ba_q_ff <= lvl_rd_ff.volume;
            end
         end
      end
   end

   // response register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status          <= res_status_ff;
         rsp_level_volume    <= res_vol_ff;
         rsp_level_orders    <= res_cnt_ff;
         rsp_best_bid_valid  <= bb_v_ff;
         rsp_best_bid_price  <= bb_p_ff;
         rsp_best_bid_volume <= bb_q_ff;
         rsp_best_ask_valid  <= ba_v_ff;
         rsp_best_ask_price  <= ba_p_ff;
         rsp_best_ask_volume <= ba_q_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status to the sequencer
   assign sts.ord_last      = (ocnt_ff == ORD_AW'(ORD_SLOTS - 1));
   assign sts.lvl_side_last = (lcnt_ff == LVL_AW'(LVL_SIDE - 1));
   assign sts.lvl_all_last  = (lcnt_ff == LVL_AW'(LVL_TOTAL - 1));
   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== hdl/lob_checker.sv =====
// port-level checks for the order book engine, bound to the top level
// depends on lob_pkg and limit_order_book_engine
module lob_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_level_volume,
   input logic [10:0] rsp_level_orders,
   input logic        rsp_best_bid_valid,
   input logic [31:0] rsp_best_bid_price,
   input logic [31:0] rsp_best_bid_volume
);
   import lob_pkg::*;

   // clearing pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken during clearing pass");

   // one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken while busy");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped under stall");

   // failed word reports an empty level
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_level_volume == 32'd0 && rsp_level_orders == 11'd0))
      else $error("failed word reports level data");

   // missing best bid reads as zero
   a_no_bid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_best_bid_valid) |->
      (rsp_best_bid_price == 32'd0 && rsp_best_bid_volume == 32'd0))
      else $error("best bid data without a bid level");

endmodule

bind limit_order_book_engine lob_checker u_lob_checker (.*);
